[design/llmsr_pkg.sv]
// ----------------------------------------------------------------------------
// llmsr_pkg: shared types for the box list core
// Opcodes, micro-step addresses, control word and status bundle used by the
// sequencer, the datapath and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package llmsr_pkg;

   localparam int OPCODE_W = 3;
   localparam int BOX_W    = 11;
   localparam int SUM_W    = 20;
   localparam int STEP_W   = 4;

   localparam logic [BOX_W-1:0] BOX_COUNT_RESET = 11'd1024;

   // Request opcodes; codes 6 and 7 are accepted and dropped
   typedef enum logic [OPCODE_W-1:0] {
      OP_REBUILD = 3'd0,
      OP_BEFORE  = 3'd1,
      OP_AFTER   = 3'd2,
      OP_SWAP    = 3'd3,
      OP_REVERSE = 3'd4,
      OP_QUERY   = 3'd5
   } op_type;

   // Micro-program addresses
   typedef enum logic [STEP_W-1:0] {
      STEP_IDLE     = 4'd0,
      STEP_MV_RD_Y  = 4'd1,
      STEP_MV_RD_X  = 4'd2,
      STEP_MV_CHECK = 4'd3,
      STEP_MV_J0    = 4'd4,
      STEP_MV_J1    = 4'd5,
      STEP_MV_J2    = 4'd6,
      STEP_MV_J3    = 4'd7,
      STEP_RB_INIT  = 4'd8,
      STEP_RB_LOOP  = 4'd9,
      STEP_RB_HEAD  = 4'd10,
      STEP_REV      = 4'd11,
      STEP_Q_INIT   = 4'd12,
      STEP_Q_LOOP   = 4'd13,
      STEP_Q_OUT    = 4'd14
   } step_type;

   // Branch conditions of a control word
   typedef enum logic [2:0] {
      COND_NEXT,
      COND_ALWAYS,
      COND_DISPATCH,
      COND_SKIP,
      COND_NOT_FAR,
      COND_MORE
   } cond_type;

   // Link table read address source
   typedef enum logic [2:0] {
      RD_NONE,
      RD_Y,
      RD_X,
      RD_HEAD,
      RD_CHAIN
   } rd_type;

   // Link table write source
   typedef enum logic [1:0] {
      WR_NONE,
      WR_JOIN,
      WR_ENTRY,
      WR_HEAD
   } wr_type;

   // One micro-program control word
   typedef struct packed {
      cond_type   cond;
      step_type   target;
      rd_type     rd;
      wr_type     wr;
      logic [1:0] slot;
      logic       cap_y;
      logic       cap_x;
      logic       cnt_init;
      logic       cnt_inc;
      logic       sum_acc;
      logic       flag_clr;
      logic       flag_tgl;
      logic       emit;
   } ucode_type;

   // Datapath status seen by the branch logic
   typedef struct packed {
      logic skip_move;
      logic not_far;
      logic cnt_last;
      logic out_busy;
   } status_type;

endpackage

`default_nettype wire

[design/linked_list_move_swap_reverse_core.sv]
// A move already in place ends after the neighbour check; a far swap does one more
//   join than a move or an adjacent swap. A query also waits while the previous
//   result is held.
// Throughput: one request at a time; one link read or one join per cycle.
// Reset: synchronous, clears the sequencer, reversal flag, result valid and
//   sets box_count to 1024; link tables are not cleared and need a rebuild.
// ----------------------------------------------------------------------------
// linked_list_move_swap_reverse_core: microcoded box list engine
// Rebuilds, relinks, reverses and queries a doubly linked list of boxes kept
// in next and previous link memories.
// ----------------------------------------------------------------------------
`default_nettype none

module linked_list_move_swap_reverse_core
   import llmsr_pkg::*;
#(
   parameter int MAX_BOXES = 1024
)
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                csr_write_enable,
   input  wire logic [BOX_W-1:0]    csr_write_data,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic [OPCODE_W-1:0] req_opcode,
   input  wire logic [BOX_W-1:0]    req_first_box,
   input  wire logic [BOX_W-1:0]    req_second_box,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic [SUM_W-1:0]         rsp_odd_position_sum
);

   localparam int PTR_W = $clog2(MAX_BOXES + 1);

   logic [BOX_W-1:0] box_count_ff;
   logic [PTR_W-1:0] box_limit;
   logic             accept;
   logic             relink_ok;
   step_type         step;
   ucode_type        ctrl;
   status_type       status;

   // Box count register
   always_ff @(posedge clock) begin
      if (reset) begin
         box_count_ff <= BOX_COUNT_RESET;
      end else if (csr_write_enable) begin
         box_count_ff <= csr_write_data;
      end
   end

   // Clamp the box count to 1..MAX_BOXES
   always_comb begin
      if (box_count_ff == '0) begin
         box_limit = PTR_W'(1);
      end else if (32'(box_count_ff) > 32'(MAX_BOXES)) begin
         box_limit = PTR_W'(MAX_BOXES);
      end else begin
         box_limit = PTR_W'(box_count_ff);
      end
   end

   // Drop relinks with equal or out-of-range boxes
   assign relink_ok = (req_first_box != req_second_box) &&
                      (req_first_box != '0) && (req_second_box != '0) &&
                      (32'(req_first_box) <= 32'(box_limit)) &&
                      (32'(req_second_box) <= 32'(box_limit));

   assign req_ready = (step == STEP_IDLE);
   assign accept    = req_valid && req_ready;

   llmsr_sequencer u_seq (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .opcode    (req_opcode),
      .relink_ok (relink_ok),
      .status    (status),
      .step      (step),
      .ctrl      (ctrl)
   );

   llmsr_datapath #(
      .MAX_BOXES (MAX_BOXES)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .accept     (accept),
      .opcode     (req_opcode),
      .first_box  (req_first_box),
      .second_box (req_second_box),
      .box_limit  (box_limit),
      .rsp_ready  (rsp_ready),
      .status     (status),
      .rsp_valid  (rsp_valid),
      .rsp_sum    (rsp_odd_position_sum)
   );

   // A new result only comes from the output step
   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(step) == STEP_Q_OUT)
      else $error("result raised outside the output step");

   // A query request enters the walk
   a_query_entry: assert property (@(posedge clock) disable iff (reset)
      (accept && req_opcode == OP_QUERY) |=> step == STEP_Q_INIT)
      else $error("query request did not start the walk");

   // A rebuild request enters the rebuild program
   a_rebuild_entry: assert property (@(posedge clock) disable iff (reset)
      (accept && req_opcode == OP_REBUILD) |=> step == STEP_RB_INIT)
      else $error("rebuild request did not start the rebuild");

   // A dropped relink leaves the block ready
   a_bad_relink: assert property (@(posedge clock) disable iff (reset)
      (accept && !relink_ok && (req_opcode == OP_BEFORE ||
       req_opcode == OP_AFTER || req_opcode == OP_SWAP)) |=> req_ready)
      else $error("dropped relink did not return to idle");

endmodule

`default_nettype wire

[design/llmsr_sequencer.sv]
// ----------------------------------------------------------------------------
// llmsr_sequencer: micro-program step counter and control store
// Holds the step register, reads the control word from a constant table and
// resolves dispatch and conditional jumps.
// ----------------------------------------------------------------------------
`default_nettype none

module llmsr_sequencer
   import llmsr_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        accept,
   input  wire logic [OPCODE_W-1:0] opcode,
   input  wire logic        relink_ok,
   input  wire status_type  status,
   output step_type         step,
   output ucode_type        ctrl
);

   step_type step_ff;
   step_type step_in;
   step_type step_inc;
   step_type entry;

   // Control store: one word per step
   function automatic ucode_type ucode_rom(input step_type s);
      ucode_type w;
      w = '{cond: COND_NEXT, target: STEP_IDLE, rd: RD_NONE, wr: WR_NONE,
            slot: 2'd0, default: 1'b0};
      case (s)
         STEP_IDLE:     w.cond = COND_DISPATCH;
         STEP_MV_RD_Y:  w.rd = RD_Y;
         STEP_MV_RD_X:  begin
            w.rd = RD_X;
            w.cap_y = 1'b1;
         end
         STEP_MV_CHECK: begin
            w.cap_x = 1'b1;
            w.cond = COND_SKIP;
            w.target = STEP_IDLE;
         end
         STEP_MV_J0:    begin
            w.wr = WR_JOIN;
            w.slot = 2'd0;
         end
         STEP_MV_J1:    begin
            w.wr = WR_JOIN;
            w.slot = 2'd1;
         end
         STEP_MV_J2:    begin
            w.wr = WR_JOIN;
            w.slot = 2'd2;
            w.cond = COND_NOT_FAR;
            w.target = STEP_IDLE;
         end
         STEP_MV_J3:    begin
            w.wr = WR_JOIN;
            w.slot = 2'd3;
            w.cond = COND_ALWAYS;
            w.target = STEP_IDLE;
         end
         STEP_RB_INIT:  begin
            w.cnt_init = 1'b1;
            w.flag_clr = 1'b1;
         end
         STEP_RB_LOOP:  begin
            w.wr = WR_ENTRY;
            w.cnt_inc = 1'b1;
            w.cond = COND_MORE;
            w.target = STEP_RB_LOOP;
         end
         STEP_RB_HEAD:  begin
            w.wr = WR_HEAD;
            w.cond = COND_ALWAYS;
            w.target = STEP_IDLE;
         end
         STEP_REV:      begin
            w.flag_tgl = 1'b1;
            w.cond = COND_ALWAYS;
            w.target = STEP_IDLE;
         end
         STEP_Q_INIT:   begin
            w.rd = RD_HEAD;
            w.cnt_init = 1'b1;
         end
         STEP_Q_LOOP:   begin
            w.rd = RD_CHAIN;
            w.sum_acc = 1'b1;
            w.cnt_inc = 1'b1;
            w.cond = COND_MORE;
            w.target = STEP_Q_LOOP;
         end
         STEP_Q_OUT:    begin
            w.emit = 1'b1;
            w.cond = COND_ALWAYS;
            w.target = STEP_IDLE;
         end
         default:       begin
            w.cond = COND_ALWAYS;
            w.target = STEP_IDLE;
         end
      endcase
      return w;
   endfunction

   // Hold the step register
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

   // Pick the program entry for an accepted request
   always_comb begin
      case (op_type'(opcode))
         OP_REBUILD: entry = STEP_RB_INIT;
         OP_BEFORE,
         OP_AFTER,
         OP_SWAP:    entry = relink_ok ? STEP_MV_RD_Y : STEP_IDLE;
         OP_REVERSE: entry = STEP_REV;
         OP_QUERY:   entry = STEP_Q_INIT;
         default:    entry = STEP_IDLE;
      endcase
   end

   // Advance, branch or hold
   always_comb begin
      ctrl     = ucode_rom(step_ff);
      step_inc = step_type'(step_ff + STEP_W'(1));
      case (ctrl.cond)
         COND_NEXT:     step_in = step_inc;
         COND_ALWAYS:   step_in = ctrl.target;
         COND_DISPATCH: step_in = accept ? entry : step_ff;
         COND_SKIP:     step_in = status.skip_move ? ctrl.target : step_inc;
         COND_NOT_FAR:  step_in = status.not_far ? ctrl.target : step_inc;
         COND_MORE:     step_in = status.cnt_last ? step_inc : ctrl.target;
         default:       step_in = STEP_IDLE;
      endcase
      if (ctrl.emit && status.out_busy) begin
         step_in = step_ff;
      end
   end

   assign step = step_ff;

endmodule

`default_nettype wire

[design/llmsr_datapath.sv]
// ----------------------------------------------------------------------------
// llmsr_datapath: link tables and working registers
// Next and previous link memories, relink operands, walk counter, sum
// accumulator, reversal flag and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module llmsr_datapath
   import llmsr_pkg::*;
#(
   parameter int MAX_BOXES = 1024,
   localparam int PTR_W = $clog2(MAX_BOXES + 1)
)
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire ucode_type        ctrl,
   input  wire logic             accept,
   input  wire logic [OPCODE_W-1:0] opcode,
   input  wire logic [BOX_W-1:0] first_box,
   input  wire logic [BOX_W-1:0] second_box,
   input  wire logic [PTR_W-1:0] box_limit,
   input  wire logic             rsp_ready,
   output status_type            status,
   output logic                  rsp_valid,
   output logic [SUM_W-1:0]      rsp_sum
);

   localparam int PROD_W = 2 * PTR_W + 1;

   typedef enum logic [1:0] {
      KIND_BEFORE,
      KIND_AFTER,
      KIND_SWAP
   } kind_type;

   typedef enum logic [2:0] {
      JOIN_BEFORE,
      JOIN_AFTER,
      JOIN_SWAP_NEXT,
      JOIN_SWAP_PREV,
      JOIN_SWAP_FAR
   } join_type;

   logic [PTR_W-1:0] next_mem [0:MAX_BOXES];
   logic [PTR_W-1:0] prev_mem [0:MAX_BOXES];

   logic [PTR_W-1:0] next_q_ff, prev_q_ff;
   logic [PTR_W-1:0] x_ff, y_ff, n_ff;
   logic [PTR_W-1:0] lx_ff, rx_ff, ly_ff, ry_ff;
   logic [PTR_W-1:0] cnt_ff;
   logic [SUM_W-1:0] sum_ff, tri_ff, rsp_sum_ff, rsp_sum_in;
   logic             rev_ff, rsp_valid_ff, rsp_valid_in;
   kind_type         kind_ff, kind_in;
   join_type         jk;

   logic [PTR_W-1:0] rd_addr;
   logic [PTR_W-1:0] ja, jb;
   logic             next_we, prev_we;
   logic [PTR_W-1:0] next_wa, next_wd, prev_wa, prev_wd;
   logic [PROD_W-1:0] prod;
   logic             load_rsp;

   // Map out-of-range links onto the sentinel
   function automatic logic [PTR_W-1:0] fix_idx(input logic [PTR_W-1:0] a);
      return (a > PTR_W'(MAX_BOXES)) ? '0 : a;
   endfunction

   // Resolve the effective relink kind under reversal
   always_comb begin
      case (op_type'(opcode))
         OP_BEFORE: kind_in = rev_ff ? KIND_AFTER : KIND_BEFORE;
         OP_AFTER:  kind_in = rev_ff ? KIND_BEFORE : KIND_AFTER;
         default:   kind_in = KIND_SWAP;
      endcase
   end

   // Latch request operands
   always_ff @(posedge clock) begin
      if (accept) begin
         x_ff    <= PTR_W'(first_box);
         y_ff    <= PTR_W'(second_box);
         n_ff    <= box_limit;
         kind_ff <= kind_in;
      end
   end

   // Capture neighbor links
   always_ff @(posedge clock) begin
      if (ctrl.cap_y) begin
         ly_ff <= prev_q_ff;
         ry_ff <= next_q_ff;
      end
      if (ctrl.cap_x) begin
         lx_ff <= prev_q_ff;
         rx_ff <= next_q_ff;
      end
   end

   // Pick the relink case
   always_comb begin
      case (kind_ff)
         KIND_BEFORE: jk = JOIN_BEFORE;
         KIND_AFTER:  jk = JOIN_AFTER;
         default: begin
            if (rx_ff == y_ff) begin
               jk = JOIN_SWAP_NEXT;
            end else if (lx_ff == y_ff) begin
               jk = JOIN_SWAP_PREV;
            end else begin
               jk = JOIN_SWAP_FAR;
            end
         end
      endcase
   end

   // Select the pair joined in this slot
   always_comb begin
      ja = '0;
      jb = '0;
      case (jk)
         JOIN_BEFORE: begin
            case (ctrl.slot)
               2'd0:    begin ja = ly_ff; jb = x_ff;  end
               2'd1:    begin ja = x_ff;  jb = y_ff;  end
               default: begin ja = lx_ff; jb = rx_ff; end
            endcase
         end
         JOIN_AFTER: begin
            case (ctrl.slot)
               2'd0:    begin ja = y_ff;  jb = x_ff;  end
               2'd1:    begin ja = x_ff;  jb = ry_ff; end
               default: begin ja = lx_ff; jb = rx_ff; end
            endcase
         end
         JOIN_SWAP_NEXT: begin
            case (ctrl.slot)
               2'd0:    begin ja = lx_ff; jb = y_ff;  end
               2'd1:    begin ja = y_ff;  jb = x_ff;  end
               default: begin ja = x_ff;  jb = ry_ff; end
            endcase
         end
         JOIN_SWAP_PREV: begin
            case (ctrl.slot)
               2'd0:    begin ja = ly_ff; jb = x_ff;  end
               2'd1:    begin ja = x_ff;  jb = y_ff;  end
               default: begin ja = y_ff;  jb = rx_ff; end
            endcase
         end
         default: begin
            case (ctrl.slot)
               2'd0:    begin ja = lx_ff; jb = y_ff;  end
               2'd1:    begin ja = y_ff;  jb = rx_ff; end
               2'd2:    begin ja = ly_ff; jb = x_ff;  end
               default: begin ja = x_ff;  jb = ry_ff; end
            endcase
         end
      endcase
   end

   // Drive table writes
   always_comb begin
      next_we = 1'b0;
      prev_we = 1'b0;
      next_wa = '0;
      next_wd = '0;
      prev_wa = '0;
      prev_wd = '0;
      case (ctrl.wr)
         WR_JOIN: begin
            next_we = 1'b1;
            prev_we = 1'b1;
            next_wa = fix_idx(ja);
            next_wd = fix_idx(jb);
            prev_wa = fix_idx(jb);
            prev_wd = fix_idx(ja);
         end
         WR_ENTRY: begin
            next_we = 1'b1;
            prev_we = 1'b1;
            next_wa = cnt_ff;
            next_wd = (cnt_ff == n_ff) ? '0 : cnt_ff + PTR_W'(1);
            prev_wa = cnt_ff;
            prev_wd = cnt_ff - PTR_W'(1);
         end
         WR_HEAD: begin
            next_we = 1'b1;
            prev_we = 1'b1;
            next_wd = PTR_W'(1);
            prev_wd = n_ff;
         end
         default: begin
            next_we = 1'b0;
         end
      endcase
   end

   // Select the read address
   always_comb begin
      case (ctrl.rd)
         RD_Y:     rd_addr = y_ff;
         RD_X:     rd_addr = x_ff;
         RD_CHAIN: rd_addr = fix_idx(next_q_ff);
         default:  rd_addr = '0;
      endcase
   end

   // Link memories with registered reads
   always_ff @(posedge clock) begin
      if (next_we) begin
         next_mem[next_wa] <= next_wd;
      end
      next_q_ff <= next_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (prev_we) begin
         prev_mem[prev_wa] <= prev_wd;
      end
      prev_q_ff <= prev_mem[rd_addr];
   end

   // Walk counter and odd-position sum
   always_ff @(posedge clock) begin
      if (ctrl.cnt_init) begin
         cnt_ff <= PTR_W'(1);
         sum_ff <= '0;
      end else begin
         if (ctrl.cnt_inc) begin
            cnt_ff <= cnt_ff + PTR_W'(1);
         end
         if (ctrl.sum_acc && cnt_ff[0]) begin
            sum_ff <= sum_ff + SUM_W'(next_q_ff);
         end
      end
   end

   // Triangular number of the box count, modulo the sum width
   assign prod = PROD_W'(n_ff) * (PROD_W'(n_ff) + PROD_W'(1));

   always_ff @(posedge clock) begin
      tri_ff <= SUM_W'(prod >> 1);
   end

   // Reversal flag
   always_ff @(posedge clock) begin
      if (reset) begin
         rev_ff <= 1'b0;
      end else if (ctrl.flag_clr) begin
         rev_ff <= 1'b0;
      end else if (ctrl.flag_tgl) begin
         rev_ff <= ~rev_ff;
      end
   end

   // Result register
   assign load_rsp = ctrl.emit && !(rsp_valid_ff && !rsp_ready);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_sum_in   = rsp_sum_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_sum_in   = (rev_ff && !n_ff[0]) ? tri_ff - sum_ff : sum_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_sum_ff <= rsp_sum_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_sum   = rsp_sum_ff;

   // Status for the branch logic
   always_comb begin
      status.skip_move = (kind_ff == KIND_BEFORE && ly_ff == x_ff) ||
                         (kind_ff == KIND_AFTER && ry_ff == x_ff);
      status.not_far   = (jk != JOIN_SWAP_FAR);
      status.cnt_last  = (cnt_ff == n_ff);
      status.out_busy  = rsp_valid_ff && !rsp_ready;
   end

endmodule

`default_nettype wire

[dv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: box list core testbench
// Drives rebuild, move, swap, reverse and query requests with random gaps on
// both channels, tracks the list in a scoreboard that mirrors the link tables,
// and compares every odd position sum in order. The box count register is
// changed between phases while the core is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
   import llmsr_pkg::*;

   localparam int unsigned BOX_LIMIT      = 1024;
   localparam int unsigned TIMEOUT_CYCLES = 1_500_000;
   localparam logic [OPCODE_W-1:0] OP_SPARE_LO = 3'd6;
   localparam logic [OPCODE_W-1:0] OP_SPARE_HI = 3'd7;

   // Mirror of the list; predicts the sum for every query request
   class box_list_scoreboard;
      logic [BOX_W-1:0] next_link [0:BOX_LIMIT];
      logic [BOX_W-1:0] prev_link [0:BOX_LIMIT];
      bit               flipped;
      logic [BOX_W-1:0] count_csr;
      logic [SUM_W-1:0] sum_queue [$];
      int               errors;

      function void clear();
         for (int i = 0; i <= BOX_LIMIT; i++) begin
            next_link[i] = '0;
            prev_link[i] = '0;
         end
         flipped   = 1'b0;
         count_csr = BOX_COUNT_RESET;
         errors    = 0;
      endfunction

      function void set_box_count(logic [BOX_W-1:0] value);
         count_csr = value;
      endfunction

      function int unsigned pending();
         return sum_queue.size();
      endfunction

      // Clamp the register to 1..BOX_LIMIT
      function int unsigned box_total();
         if (count_csr < 1) return 1;
         if (count_csr > BOX_LIMIT) return BOX_LIMIT;
         return 32'(count_csr);
      endfunction

      function int unsigned clip(int unsigned idx);
         return (idx <= BOX_LIMIT) ? idx : 0;
      endfunction

      function void link(int unsigned a, int unsigned b);
         next_link[clip(a)] = BOX_W'(b);
         prev_link[clip(b)] = BOX_W'(a);
      endfunction

      function void rebuild(int unsigned n);
         for (int unsigned i = 1; i <= n; i++) begin
            next_link[i] = (i == n) ? '0 : BOX_W'(i + 1);
            prev_link[i] = BOX_W'(i - 1);
         end
         next_link[0] = BOX_W'(1);
         prev_link[0] = BOX_W'(n);
         flipped = 1'b0;
      endfunction

      function void relink(logic [OPCODE_W-1:0] op, int unsigned x, int unsigned y);
         logic [OPCODE_W-1:0] mode;
         int unsigned lx, rx, ly, ry;
         mode = op;
         // reversal swaps the sense of before and after
         if (flipped && op == OP_BEFORE) mode = OP_AFTER;
         else if (flipped && op == OP_AFTER) mode = OP_BEFORE;
         if (mode == OP_BEFORE && prev_link[y] == x) return;
         if (mode == OP_AFTER && next_link[y] == x) return;
         lx = prev_link[x];
         rx = next_link[x];
         ly = prev_link[y];
         ry = next_link[y];
         if (mode == OP_BEFORE) begin
            link(ly, x); link(x, y); link(lx, rx);
         end else if (mode == OP_AFTER) begin
            link(y, x); link(x, ry); link(lx, rx);
         end else if (rx == y) begin
            link(lx, y); link(y, x); link(x, ry);
         end else if (lx == y) begin
            link(ly, x); link(x, y); link(y, rx);
         end else begin
            link(lx, y); link(y, rx); link(ly, x); link(x, ry);
         end
      endfunction

      // Walk n links from the sentinel, summing labels at odd positions
      function logic [SUM_W-1:0] odd_sum(int unsigned n);
         int unsigned cur;
         longint      total;
         cur   = 0;
         total = 0;
         for (int unsigned i = 1; i <= n; i++) begin
            cur = next_link[clip(cur)];
            if (i % 2 == 1) total += cur;
         end
         if (flipped && n % 2 == 0) total = longint'(n) * longint'(n + 1) / 2 - total;
         return total[SUM_W-1:0];
      endfunction

      function void note_request(logic [OPCODE_W-1:0] op, logic [BOX_W-1:0] x,
                                 logic [BOX_W-1:0] y);
         int unsigned n;
         n = box_total();
         case (op)
            OP_REBUILD: rebuild(n);
            OP_REVERSE: flipped = !flipped;
            OP_QUERY: sum_queue.push_back(odd_sum(n));
            OP_BEFORE, OP_AFTER, OP_SWAP: begin
               if (x != y && x >= 1 && y >= 1 && x <= n && y <= n) relink(op, x, y);
            end
            default: ;
         endcase
      endfunction

      function void check_sum(logic [SUM_W-1:0] got);
         logic [SUM_W-1:0] want;
         if (sum_queue.size() == 0) begin
            $display("%0t: unexpected odd_position_sum, expected none, actual %0d",
                     $time, got);
            errors++;
            return;
         end
         want = sum_queue.pop_front();
         if (got !== want) begin
            $display("%0t: odd_position_sum mismatch, expected %0d, actual %0d",
                     $time, want, got);
            errors++;
         end
      endfunction
   endclass

   logic                clock            = 1'b0;
   logic                reset            = 1'b1;
   logic                csr_write_enable = 1'b0;
   logic [BOX_W-1:0]    csr_write_data   = '0;
   logic                req_valid        = 1'b0;
   logic                req_ready;
   logic [OPCODE_W-1:0] req_opcode       = '0;
   logic [BOX_W-1:0]    req_first_box    = '0;
   logic [BOX_W-1:0]    req_second_box   = '0;
   logic                rsp_valid;
   logic                rsp_ready        = 1'b0;
   logic [SUM_W-1:0]    rsp_odd_position_sum;
   bit                  calm             = 1'b0;

   box_list_scoreboard books = new;

   linked_list_move_swap_reverse_core #(
      .MAX_BOXES(BOX_LIMIT)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .csr_write_enable(csr_write_enable),
      .csr_write_data(csr_write_data),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_opcode(req_opcode),
      .req_first_box(req_first_box),
      .req_second_box(req_second_box),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_odd_position_sum(rsp_odd_position_sum)
   );

   always #5 clock = ~clock;

   // Stall the result side at random, except in the calm phase
   always @(posedge clock) begin
      rsp_ready <= calm || ($urandom_range(0, 99) >= 30);
   end

   // Check each sum as it is taken
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) books.check_sum(rsp_odd_position_sum);
   end

   // Present one request and hold it until accepted
   task automatic send_request(input logic [OPCODE_W-1:0] op, input logic [BOX_W-1:0] x,
                               input logic [BOX_W-1:0] y);
      req_valid      <= 1'b1;
      req_opcode     <= op;
      req_first_box  <= x;
      req_second_box <= y;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      books.note_request(op, x, y);
   endtask

   task automatic pause_sender(input int unsigned cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Hold off until every sum is back; optionally let a full walk finish
   task automatic wait_results(input bit settle);
      req_valid <= 1'b0;
      while (books.pending() != 0) @(posedge clock);
      if (settle) repeat (books.box_total() + 16) @(posedge clock);
   endtask

   task automatic write_box_count(input logic [BOX_W-1:0] value);
      wait_results(1'b1);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      books.set_box_count(value);
   endtask

   // Mostly valid boxes, some zero and some beyond the count
   function automatic logic [BOX_W-1:0] pick_box(input int unsigned n);
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 92) return BOX_W'($urandom_range(1, n));
      if (r < 95) return '0;
      return BOX_W'($urandom_range(0, (1 << BOX_W) - 1));
   endfunction

   // Mostly relinks; fewer walks when the list is long
   function automatic logic [OPCODE_W-1:0] pick_opcode(input bit few_walks);
      int unsigned r;
      r = $urandom_range(0, 999);
      if (r < (few_walks ? 5 : 20)) return OP_REBUILD;
      if (r < (few_walks ? 35 : 120)) return OP_QUERY;
      if (r < (few_walks ? 105 : 190)) return OP_REVERSE;
      if (r < (few_walks ? 115 : 200)) return OP_SPARE_LO;
      if (r < (few_walks ? 125 : 210)) return OP_SPARE_HI;
      case (r % 3)
         0: return OP_BEFORE;
         1: return OP_AFTER;
         default: return OP_SWAP;
      endcase
   endfunction

   initial begin
      logic [BOX_W-1:0] phase_counts [10];
      int unsigned      n;
      int unsigned      items;
      bit               few_walks;

      books.clear();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Count after reset, then reversed with an even count
      send_request(OP_REBUILD, 11'd0, 11'd0);
      send_request(OP_QUERY, 11'd0, 11'd0);
      send_request(OP_REVERSE, 11'd2047, 11'd2047);
      send_request(OP_QUERY, 11'd0, 11'd0);

      // Short list: every command and each ignored case
      write_box_count(11'd6);
      send_request(OP_REBUILD, 11'd0, 11'd0);
      send_request(OP_QUERY, 11'd0, 11'd0);
      send_request(OP_BEFORE, 11'd3, 11'd5);
      send_request(OP_AFTER, 11'd1, 11'd6);
      send_request(OP_BEFORE, 11'd4, 11'd3);
      send_request(OP_AFTER, 11'd1, 11'd6);
      send_request(OP_SWAP, 11'd2, 11'd4);
      send_request(OP_SWAP, 11'd3, 11'd2);
      send_request(OP_SWAP, 11'd4, 11'd1);
      send_request(OP_QUERY, 11'd0, 11'd0);
      send_request(OP_REVERSE, 11'd0, 11'd0);
      send_request(OP_BEFORE, 11'd5, 11'd2);
      send_request(OP_AFTER, 11'd2, 11'd6);
      send_request(OP_QUERY, 11'd0, 11'd0);
      send_request(OP_SWAP, 11'd3, 11'd3);
      send_request(OP_BEFORE, 11'd0, 11'd2);
      send_request(OP_AFTER, 11'd2, 11'd2047);
      send_request(OP_SPARE_LO, 11'd1, 11'd2);
      send_request(OP_SPARE_HI, 11'd2, 11'd1);
      send_request(OP_QUERY, 11'd0, 11'd0);
      send_request(OP_REBUILD, 11'd0, 11'd0);
      send_request(OP_QUERY, 11'd0, 11'd0);

      // Random phases; each starts with a rebuild so no link is read unwritten
      phase_counts = '{11'd0, 11'd1, 11'd2, 11'd3, 11'd8, 11'd2047, 11'd11, 11'd1024,
                       BOX_W'($urandom_range(4, 40)), BOX_W'($urandom_range(4, 40))};
      foreach (phase_counts[p]) begin
         write_box_count(phase_counts[p]);
         calm <= (p == 4);
         n         = books.box_total();
         few_walks = (n > 64);
         items     = few_walks ? 60 : 230;
         send_request(OP_REBUILD, pick_box(n), pick_box(n));
         for (int unsigned k = 1; k < items; k++) begin
            if (k == items / 2) wait_results(1'b0);
            if (p != 4 && $urandom_range(0, 99) < 30) pause_sender($urandom_range(1, 4));
            send_request(pick_opcode(few_walks), pick_box(n), pick_box(n));
         end
      end
      calm <= 1'b0;

      wait_results(1'b1);
      if (books.errors == 0 && books.pending() == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

   // Stop a hung run
   initial begin
      #(TIMEOUT_CYCLES * 10);
      $display("tb_top NOT OK");
      $finish;
   end

endmodule

`default_nettype wire

[linked_list_move_swap_reverse_core.f]
design/llmsr_pkg.sv
design/llmsr_sequencer.sv
design/llmsr_datapath.sv
design/linked_list_move_swap_reverse_core.sv
dv/tb_top.sv
